/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file ppbfc_checker.sv.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Property checked during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/ppbfc_pkg.sv */
// Types and constants for the five-character offset formatter.
// No dependencies.
package ppbfc_pkg;

  localparam int unsigned NumCells = 10;

  localparam logic [6:0] ChSpace = 7'h20;
  localparam logic [6:0] ChMinus = 7'h2d;
  localparam logic [6:0] ChDot   = 7'h2e;
  localparam logic [6:0] ChSlash = 7'h2f;
  localparam logic [6:0] ChZero  = 7'h30;
  localparam logic [6:0] ChA     = 7'h41;
  localparam logic [6:0] ChK     = 7'h4b;
  localparam logic [6:0] ChM     = 7'h4d;
  localparam logic [6:0] ChN     = 7'h4e;

  typedef enum logic [2:0] {
    MODE_NA,
    MODE_SMALL,
    MODE_TENTHS,
    MODE_UNIT,
    MODE_KILO,
    MODE_MEGA
  } mode_t;

  typedef struct packed {
    logic        valid;
    mode_t       mode;
    logic        neg;
    logic [31:0] rem;
    logic [3:0]  d3;
    logic [3:0]  d2;
    logic [3:0]  d1;
    logic [3:0]  d0;
    logic [3:0]  d4;
  } cell_t;

endpackage

/* rtl/core/ppbfc_cell.sv */
// One cell of the digit chain: peels one decimal digit off the remainder.
// Depends on ppbfc_pkg.
module ppbfc_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  ppbfc_pkg::cell_t  din,
  output ppbfc_pkg::cell_t  dout
);
  import ppbfc_pkg::*;

  cell_t       nxt;
  logic [31:0] q;
  logic [34:0] prod;

  always_comb begin
    prod = 35'(({32'd0, din.rem} * 64'hCCCCCCCD) >> 35);
    q    = prod[31:0];
    nxt  = din;
    nxt.rem = q;
    nxt.d4  = din.d3;
    nxt.d3  = din.d2;
    nxt.d2  = din.d1;
    nxt.d1  = din.d0;
    nxt.d0  = 4'(din.rem - q * 32'd10);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.mode <= nxt.mode;
      dout.neg  <= nxt.neg;
      dout.rem  <= nxt.rem;
      dout.d4   <= nxt.d4;
      dout.d3   <= nxt.d3;
      dout.d2   <= nxt.d2;
      dout.d1   <= nxt.d1;
      dout.d0   <= nxt.d0;
    end
  end
endmodule

/* rtl/core/ppbfc_front.sv */
// Entry stage: marker compare, magnitude, range select and rounding.
// Depends on ppbfc_pkg.
module ppbfc_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [31:0]       value,
  input  logic [31:0]       marker,
  output ppbfc_pkg::cell_t  dout
);
  import ppbfc_pkg::*;

  logic        neg;
  logic [31:0] mag;
  cell_t       nxt;

  always_comb begin
    neg = value[31];
    mag = neg ? (32'd0 - value) : value;
    nxt = '0;
    nxt.valid = in_valid;
    nxt.neg   = neg;
    priority if (value == marker) begin
      nxt.mode = MODE_NA;
    end else if (mag < 32'd1000) begin
      nxt.mode = MODE_SMALL;
      nxt.rem  = mag;
    end else if (mag < 32'd9995) begin
      nxt.mode = MODE_TENTHS;
      nxt.rem  = mag + 32'd5;
    end else if (mag < 32'd999950) begin
      nxt.mode = MODE_UNIT;
      nxt.rem  = mag + 32'd50;
    end else if (mag < 32'd99950000) begin
      nxt.mode = MODE_KILO;
      nxt.rem  = mag + 32'd50000;
    end else begin
      nxt.mode = MODE_MEGA;
      nxt.rem  = mag + 32'd50000000;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nxt.valid;
    end
    if (en) begin
      dout.mode <= nxt.mode;
      dout.neg  <= nxt.neg;
      dout.rem  <= nxt.rem;
      dout.d4   <= nxt.d4;
      dout.d3   <= nxt.d3;
      dout.d2   <= nxt.d2;
      dout.d1   <= nxt.d1;
      dout.d0   <= nxt.d0;
    end
  end
endmodule

/* rtl/core/ppbfc_render.sv */
// Output stage: picks the kept digits per range and lays out characters.
// Depends on ppbfc_pkg.
module ppbfc_render (
  input  ppbfc_pkg::cell_t  din,
  input  logic [39:0]       hist,
  output logic [6:0]        c0,
  output logic [6:0]        c1,
  output logic [6:0]        c2,
  output logic [6:0]        c3,
  output logic [6:0]        c4
);
  import ppbfc_pkg::*;

  // hist holds the ten digits, least significant at [3:0]
  logic [3:0] g [10];
  logic [6:0] sgn;
  logic [6:0] c [5];
  logic [3:0] s [5];
  logic [2:0] nd;
  logic [2:0] w;

  always_comb begin
    for (int i = 0; i < 10; i++) g[i] = hist[i*4 +: 4];
    sgn = din.neg ? ChMinus : ChSpace;
    for (int i = 0; i < 5; i++) begin
      c[i] = ChSpace;
      s[i] = 4'd0;
    end
    w = 3'd5;
    unique case (din.mode)
      MODE_KILO: begin
        w = 3'd4;
        for (int i = 0; i < 5; i++) s[i] = g[i + 5];
      end
      MODE_MEGA: begin
        w = 3'd4;
        s[0] = g[8];
        s[1] = g[9];
      end
      default: begin
        for (int i = 0; i < 5; i++) s[i] = g[i + 2];
      end
    endcase
    nd = 3'd1;
    for (int i = 1; i < 5; i++) if (s[i] != 4'd0) nd = 3'(i + 1);
    unique case (din.mode)
      MODE_NA: begin
        c[1] = ChN;
        c[2] = ChSlash;
        c[3] = ChA;
      end
      MODE_SMALL: begin
        c[0] = sgn;
        c[1] = ChZero + 7'(g[2]);
        c[2] = ChDot;
        c[3] = ChZero + 7'(g[1]);
        c[4] = ChZero + 7'(g[0]);
      end
      MODE_TENTHS: begin
        c[0] = sgn;
        c[1] = ChZero + 7'(g[3]);
        c[2] = ChZero + 7'(g[2]);
        c[3] = ChDot;
        c[4] = ChZero + 7'(g[1]);
      end
      default: begin
        if (din.mode != MODE_UNIT) c[4] = (din.mode == MODE_KILO) ? ChK : ChM;
        for (int i = 0; i < 5; i++) begin
          if (3'(i) < nd && 3'(i) < w) c[w - 3'd1 - 3'(i)] = ChZero + 7'(s[i]);
        end
        if (din.neg && nd < w) c[w - 3'd1 - nd] = ChMinus;
      end
    endcase
    c0 = c[0];
    c1 = c[1];
    c2 = c[2];
    c3 = c[3];
    c4 = c[4];
  end
endmodule

/* rtl/core/ppb_five_char_display_format_unit.sv */
// Top level of the five-character offset formatter: entry stage, digit
// chain, render stage and output register. Uses ppbfc_pkg and submodules.
//
//  channel | handshake       | payload
//  in      | in_valid/stall  | offset_value
//  out     | out_valid/stall | first_char .. fifth_char
//  cfg     | cfg_we          | cfg_data (unset_marker)
//
// One request a cycle unless stalled; stages: entry, ten digit cells, output.
// Each cell divides its remainder by ten with one reciprocal multiply.
// Reset clears the valid bits and sets the marker to the most negative value.
// A stall on the output holds the whole chain; in_stall follows it.
module ppb_five_char_display_format_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] offset_value,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  first_char,
  output logic [6:0]  second_char,
  output logic [6:0]  third_char,
  output logic [6:0]  fourth_char,
  output logic [6:0]  fifth_char
);
  import ppbfc_pkg::*;

  logic [31:0] marker;
  logic        en;
  cell_t       chain [NumCells + 1];
  logic [39:0] hist;
  logic [6:0]  r0, r1, r2, r3, r4;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      marker <= 32'h8000_0000;
    end else if (cfg_we) begin
      marker <= cfg_data;
    end
  end

  ppbfc_front u_front (
    .clk, .rst, .en, .in_valid, .value(offset_value), .marker, .dout(chain[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    ppbfc_cell u_cell (.clk, .rst, .en, .din(chain[i]), .dout(chain[i+1]));
  end

  // each cell passes five digits on; take the top five from the tail
  logic [3:0] tail_lo [5];
  assign tail_lo[0] = chain[NumCells].d0;
  assign tail_lo[1] = chain[NumCells].d1;
  assign tail_lo[2] = chain[NumCells].d2;
  assign tail_lo[3] = chain[NumCells].d3;
  assign tail_lo[4] = chain[NumCells].d4;

  logic [3:0] tail_hi [5];
  assign tail_hi[0] = chain[NumCells - 5].d0;
  assign tail_hi[1] = chain[NumCells - 5].d1;
  assign tail_hi[2] = chain[NumCells - 5].d2;
  assign tail_hi[3] = chain[NumCells - 5].d3;
  assign tail_hi[4] = chain[NumCells - 5].d4;

  // the first five digits leave the window; keep them in a side line
  logic [19:0] side [6];
  assign side[0] = {tail_hi[0], tail_hi[1], tail_hi[2], tail_hi[3], tail_hi[4]};
  for (genvar i = 0; i < 5; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) side[i+1] <= side[i];
    end
  end

  assign hist = {tail_lo[0], tail_lo[1], tail_lo[2], tail_lo[3], tail_lo[4],
                 side[5]};

  ppbfc_render u_render (
    .din(chain[NumCells]), .hist, .c0(r0), .c1(r1), .c2(r2), .c3(r3), .c4(r4)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= chain[NumCells].valid;
    end
    if (en) begin
      first_char  <= r0;
      second_char <= r1;
      third_char  <= r2;
      fourth_char <= r3;
      fifth_char  <= r4;
    end
  end
endmodule

/* rtl/core/ppbfc_checker.sv */
// Port-level checks for the offset formatter, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ppbfc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [6:0] first_char,
  input logic [6:0] fifth_char
);
  `ASSERT_CLK(a_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(first_char), "stalled result changed")
  `ASSERT_CLK(a_install, clk, rst, in_stall == (out_valid && out_stall), "input stall mismatch")
  `ASSERT_CLK(a_print, clk, rst, out_valid |-> fifth_char >= 7'h20 && fifth_char <= 7'h7e, "unprintable character")
  `ASSERT_ALWAYS(a_rst, clk, $past(rst) |-> !out_valid, "valid after reset")
endmodule

bind ppb_five_char_display_format_unit ppbfc_checker u_chk (.*);

/* sim/ppb_five_char_display_format_checker.sv */
// Checker for the five-character offset formatter: watches the request and
// result channels, predicts each result and compares it. Depends on ppbfc_pkg.
`timescale 1ns / 1ps
module ppb_five_char_display_format_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] offset_value,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [6:0]  first_char,
  input  logic [6:0]  second_char,
  input  logic [6:0]  third_char,
  input  logic [6:0]  fourth_char,
  input  logic [6:0]  fifth_char,
  output int          fail_count,
  output int          pending
);
  import ppbfc_pkg::*;

  logic [31:0] marker;
  logic [34:0] field_q [$];

  assign pending = field_q.size();

  function automatic logic [34:0] format_offset(logic [31:0] raw);
    logic [6:0] c [5];
    logic neg;
    logic [31:0] mag;
    logic [31:0] v;
    logic [31:0] t;
    int p;
    int width;
    neg = raw[31];
    mag = neg ? -raw : raw;
    for (int i = 0; i < 5; i++) c[i] = ChSpace;
    width = 5;
    v = 0;
    if (raw == marker) begin
      c[1] = ChN;
      c[2] = ChSlash;
      c[3] = ChA;
      width = 0;
    end else if (mag < 9995) begin
      c[0] = neg ? ChMinus : ChSpace;
      width = 0;
      if (mag < 1000) begin
        c[1] = ChZero + 7'(mag / 100);
        c[2] = ChDot;
        c[3] = ChZero + 7'((mag / 10) % 10);
        c[4] = ChZero + 7'(mag % 10);
      end else begin
        t = (mag + 5) / 10;
        c[1] = ChZero + 7'((t / 100) % 10);
        c[2] = ChZero + 7'((t / 10) % 10);
        c[3] = ChDot;
        c[4] = ChZero + 7'(t % 10);
      end
    end else if (mag < 999950) begin
      v = (mag + 50) / 100;
    end else if (mag < 99950000) begin
      v = (mag + 50000) / 100000;
      width = 4;
      c[4] = ChK;
    end else begin
      v = 32'((64'(mag) + 50000000) / 100000000);
      width = 4;
      c[4] = ChM;
    end
    if (width > 0) begin
      p = width - 1;
      do begin
        c[p] = ChZero + 7'(v % 10);
        v = v / 10;
        p--;
      end while (v != 0 && p >= 0);
      if (neg && p >= 0) c[p] = ChMinus;
    end
    return {c[0], c[1], c[2], c[3], c[4]};
  endfunction

  task automatic report_mismatch(string what, logic [6:0] got, logic [6:0] want);
    $display("mismatch at %0t: %s got %02h want %02h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    logic [34:0] want;
    if (rst) begin
      marker <= 32'h8000_0000;
      field_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) field_q.push_back(format_offset(offset_value));
      if (cfg_we) marker <= cfg_data;
      if (out_valid && !out_stall) begin
        if (field_q.size() == 0) begin
          $display("mismatch at %0t: result with no request waiting", $time);
          fail_count++;
        end else begin
          want = field_q.pop_front();
          if (first_char != want[34:28]) report_mismatch("first", first_char, want[34:28]);
          if (second_char != want[27:21]) report_mismatch("second", second_char, want[27:21]);
          if (third_char != want[20:14]) report_mismatch("third", third_char, want[20:14]);
          if (fourth_char != want[13:7]) report_mismatch("fourth", fourth_char, want[13:7]);
          if (fifth_char != want[6:0]) report_mismatch("fifth", fifth_char, want[6:0]);
        end
      end
    end
  end
endmodule

/* sim/ppb_five_char_display_format_unit_tb.sv */
// Testbench top for the five-character offset formatter: drives requests and
// marker writes, stalls the result side and gives the verdict from the checker.
`timescale 1ns / 1ps
module ppb_five_char_display_format_unit_tb;
  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] offset_value;
  logic        cfg_we;
  logic [31:0] cfg_data;
  logic        out_valid;
  logic        out_stall;
  logic [6:0]  first_char, second_char, third_char, fourth_char, fifth_char;
  int          fail_count;
  int          pending;
  int          cycles;
  bit          calm;

  ppb_five_char_display_format_unit dut (.*);
  ppb_five_char_display_format_checker chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("FAIL");
      $finish;
    end
  end

  int stall_left;
  always @(posedge clk) begin
    if (rst || calm) begin
      out_stall <= 0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= stall_left > 1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 4);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  function automatic logic [31:0] pick_offset();
    logic [31:0] m;
    case ($urandom_range(0, 7))
      0: m = $urandom_range(0, 1100);
      1: m = $urandom_range(9000, 11000);
      2: m = $urandom_range(990000, 1010000);
      3: m = $urandom_range(99900000, 100100000);
      4: m = $urandom_range(0, 1000000);
      5: m = 32'(($urandom_range(1, 99) * 100) + 50 - $urandom_range(0, 1));
      default: m = $urandom;
    endcase
    return ($urandom_range(0, 1) && m != 0) ? -m : m;
  endfunction

  task automatic send_offset(logic [31:0] v);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1;
    offset_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_marker(logic [31:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  logic [31:0] directed [] = '{32'h0, 32'hffff_ffff, 32'd1, 32'd999, 32'd1000, 32'd9994,
    32'd9995, -32'd9995, -32'd9994, 32'd999949, 32'd999950, -32'd999950,
    32'd99949999, 32'd99950000, -32'd99950000, 32'h7fff_ffff, 32'h8000_0000,
    32'h8000_0001, 32'd1004, 32'd1005, -32'd1, 32'd12345};
  logic [31:0] markers [] = '{32'h0, 32'h7fff_ffff, 32'hffff_ffff, 32'd12345};

  initial begin
    rst = 1;
    in_valid = 0;
    offset_value = 0;
    cfg_we = 0;
    cfg_data = 0;
    calm = 0;
    repeat (3) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) send_offset(directed[i]);
    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) write_marker(ph < 4 ? markers[ph - 1] : 32'h8000_0000 ^ $urandom);
      if (ph == 4) calm = 1;
      send_offset(chk.marker);
      for (int i = 0; i < 385; i++) send_offset($urandom_range(0, 20) == 0 ? chk.marker : pick_offset());
    end
    write_marker(markers[3]);
    send_offset(32'd12345);
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
